@@ rtl/satl_pkg.sv @@
// Shared types, constants and the exponential decay table of the tilt alarm.
// The multiplier, the alarm state and the top level refer to this package by scoped names.
package satl_pkg;

    localparam int unsigned EXP_TABLE_DEPTH = 256;
    localparam int unsigned EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    // Exponents are Q8.8; the table spans 0 to 16.0, i.e. the low 12 bits.
    localparam int unsigned EXP_X_W         = 12;
    localparam logic [15:0] EXP_X_LIMIT     = 16'd4096;

    localparam logic [31:0] BLINK_PERIOD_MS = 32'd500;

    // Digit-serial multiplier: 16-bit operands, one 4-bit digit per cycle.
    localparam int unsigned MUL_W      = 16;
    localparam int unsigned MUL_DIGIT  = 4;
    localparam int unsigned MUL_STEPS  = MUL_W / MUL_DIGIT;
    localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);

    // Configuration register indexes.
    localparam logic [2:0] REG_ANGLE_CEILING = 3'd0;
    localparam logic [2:0] REG_TIME_CEILING  = 3'd1;
    localparam logic [2:0] REG_ANGLE_DECAY   = 3'd2;
    localparam logic [2:0] REG_TIME_DECAY    = 3'd3;
    localparam logic [2:0] REG_MUTE          = 3'd4;

    typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

    // Operands of the per-sample decision.
    typedef struct packed {
        logic [16:0] mag;
        logic [15:0] alim;
        logic [15:0] tlim;
        logic [31:0] now;
        logic        mute;
    } decide_t;

    typedef struct packed {
        logic buzzer_on;
        logic led_on;
        logic alarm_on;
    } result_t;

    // exp(-16k/DEPTH) in Q0.16: short Taylor series of exp(-y/256) in Q0.32,
    // squared eight times, then rounded and saturated.
    function automatic logic [15:0] exp_entry(int unsigned k);
        logic [63:0] one;
        logic [63:0] y16;
        logic [63:0] z;
        logic [63:0] q;
        logic [63:0] r;
        one = 64'd1 << 32;
        if (k == 0) begin
            return 16'hFFFF;
        end
        y16 = (64'(k) << 20) / 64'(EXP_TABLE_DEPTH);
        z   = y16 << 8;
        q   = one;
        for (int n = 5; n >= 1; n--) begin
            q = one - (((z * q) >> 32) / 64'(n));
        end
        r = q;
        for (int s = 0; s < 8; s++) begin
            r = (r * r + (64'd1 << 31)) >> 32;
        end
        r = (r + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t tab;
        for (int unsigned k = 0; k < EXP_TABLE_DEPTH; k++) begin
            tab[k] = exp_entry(k);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    // Decay factor for a Q8.8 exponent; zero from 16.0 upward.
    function automatic logic [15:0] exp_lookup(logic [15:0] x);
        logic [31:0] p;
        p = 32'(x[EXP_X_W-1:0]) * 32'(EXP_TABLE_DEPTH);
        if (x >= EXP_X_LIMIT) begin
            return 16'd0;
        end
        return EXP_TAB[p[EXP_X_W +: EXP_IDX_W]];
    endfunction

endpackage

@@ rtl/satl_mul.sv @@
// Digit-serial 16x16 unsigned multiplier: one multiplier digit per cycle.
// Uses satl_pkg for the operand width and digit size.
module satl_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic        done,
    output logic [31:0] product
);

    localparam int unsigned PP_W = satl_pkg::MUL_W + satl_pkg::MUL_DIGIT;

    logic                            busy_reg;
    logic [satl_pkg::MUL_CNT_W-1:0]  cnt_reg;
    logic [satl_pkg::MUL_W-1:0]      a_reg;
    logic [satl_pkg::MUL_W-1:0]      hi_reg;
    logic [satl_pkg::MUL_W-1:0]      lo_reg;
    logic [PP_W-1:0]                 sum;

    // The low word doubles as the multiplier shift register: consumed digits
    // leave at the bottom while finished product bits enter at the top.
    assign sum = PP_W'(hi_reg) + PP_W'(a_reg) * PP_W'(lo_reg[satl_pkg::MUL_DIGIT-1:0]);
    assign done    = busy_reg && (cnt_reg == satl_pkg::MUL_CNT_W'(satl_pkg::MUL_STEPS - 1));
    assign product = {hi_reg, lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + satl_pkg::MUL_CNT_W'(1);
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[PP_W-1:satl_pkg::MUL_DIGIT];
            lo_reg <= {sum[satl_pkg::MUL_DIGIT-1:0], lo_reg[satl_pkg::MUL_W-1:satl_pkg::MUL_DIGIT]};
        end
    end

endmodule

@@ rtl/satl_alarm.sv @@
// Alarm state: exceed tracking, alarm flag and LED blink timing.
// Uses satl_pkg for the decision operands, the result type and the blink period.
module satl_alarm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  satl_pkg::decide_t op,
    output satl_pkg::result_t res
);

    logic        exceeding_reg, exceeding_next;
    logic [31:0] start_ms_reg, start_ms_next;
    logic        alarm_reg, alarm_next;
    logic        phase_reg, phase_next;
    logic        seen_reg, seen_next;
    logic [31:0] last_ms_reg, last_ms_next;

    logic        over_angle;
    logic [31:0] elapsed;
    logic [31:0] since_toggle;
    logic        toggle;

    assign over_angle   = op.mag > {1'b0, op.alim};
    assign elapsed      = op.now - start_ms_reg;
    assign since_toggle = op.now - last_ms_reg;

    always_comb begin
        exceeding_next = exceeding_reg;
        start_ms_next  = start_ms_reg;
        alarm_next     = alarm_reg;
        phase_next     = phase_reg;
        seen_next      = seen_reg;
        last_ms_next   = last_ms_reg;
        toggle         = 1'b0;
        if (over_angle) begin
            exceeding_next = 1'b1;
            // A fresh exceed starts at this sample, so no time has elapsed yet.
            if (!exceeding_reg) begin
                start_ms_next = op.now;
            end else if (elapsed > 32'(op.tlim)) begin
                alarm_next = 1'b1;
            end
        end else begin
            exceeding_next = 1'b0;
            alarm_next     = 1'b0;
        end
        if (alarm_next) begin
            toggle = !seen_reg || (since_toggle > satl_pkg::BLINK_PERIOD_MS);
            if (toggle) begin
                phase_next   = !phase_reg;
                last_ms_next = op.now;
                seen_next    = 1'b1;
            end
        end
        res.alarm_on  = alarm_next;
        res.led_on    = alarm_next && phase_next;
        res.buzzer_on = alarm_next && !op.mute;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exceeding_reg <= 1'b0;
            start_ms_reg  <= '0;
            alarm_reg     <= 1'b0;
            phase_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            last_ms_reg   <= '0;
        end else if (go) begin
            exceeding_reg <= exceeding_next;
            start_ms_reg  <= start_ms_next;
            alarm_reg     <= alarm_next;
            phase_reg     <= phase_next;
            seen_reg      <= seen_next;
            last_ms_reg   <= last_ms_next;
        end
    end

endmodule

@@ rtl/speed_adaptive_tilt_alarm.sv @@
// Top level of the speed adaptive tilt alarm: channels, configuration and sequencing.
// Depends on satl_pkg, satl_mul and satl_alarm.
//
// Usage: each sample transfer on the s_ channel carries pitch_delta, speed_kmh and
// now_ms. The block derives the angle and time limits from the speed, updates the
// alarm state and sends one result transfer on the m_ channel with alarm_on,
// led_on and buzzer_on.
// Configuration writes go over cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high, and writes with an index above the register list are dropped. Write only
// while no sample is in flight.
// Sequencing: a sample goes from its transfer through two digit-serial multiplier
// passes (speed times decay, then ceiling times decay factor) with the table lookup
// between them, then through the alarm decision to m_tvalid; s_tready returns in
// the same cycle as m_tvalid, so a new sample goes in only once the last one's
// result is registered.
// The result sits in an output register: the next sample is taken in while it
// waits, and only the final decision step holds off until m_tready frees it.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// alarm state and drops m_tvalid.
module speed_adaptive_tilt_alarm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [16:0] pitch_delta, [32:17] speed_kmh, [64:33] now_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] alarm_on, [1] led_on, [2] buzzer_on
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_LOOKUP,
        ST_MUL_L,
        ST_DECIDE
    } state_t;

    state_t      state_reg;

    logic [15:0] angle_ceiling_reg;
    logic [15:0] time_ceiling_reg;
    logic [15:0] angle_decay_reg;
    logic [15:0] time_decay_reg;
    logic        mute_reg;

    logic [16:0] mag_reg;
    logic [31:0] now_reg;

    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic [16:0] pitch_in;
    logic        accept;
    logic        mul_start;
    logic [15:0] mul_a_angle, mul_b_angle, mul_a_time, mul_b_time;
    logic        done_angle, done_time;
    logic [31:0] prod_angle, prod_time;
    logic [31:0] round_angle, round_time;
    logic        go;

    satl_pkg::decide_t op;
    satl_pkg::result_t res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign pitch_in  = s_tdata[16:0];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // First pass multiplies decay by speed; second pass multiplies the ceiling by
    // the factor read from the table out of the first pass's exponent.
    assign mul_start   = accept || (state_reg == ST_LOOKUP);
    assign mul_a_angle = (state_reg == ST_IDLE) ? angle_decay_reg : angle_ceiling_reg;
    assign mul_a_time  = (state_reg == ST_IDLE) ? time_decay_reg  : time_ceiling_reg;
    assign mul_b_angle = (state_reg == ST_IDLE) ? s_tdata[32:17]
                                                : satl_pkg::exp_lookup(prod_angle[31:16]);
    assign mul_b_time  = (state_reg == ST_IDLE) ? s_tdata[32:17]
                                                : satl_pkg::exp_lookup(prod_time[31:16]);

    satl_mul u_mul_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a_angle),
        .b       (mul_b_angle),
        .done    (done_angle),
        .product (prod_angle)
    );

    satl_mul u_mul_time (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a_time),
        .b       (mul_b_time),
        .done    (done_time),
        .product (prod_time)
    );

    // A 16x16 product is at most 2^32 - 2^17 + 1, so the rounding add cannot carry out.
    assign round_angle = prod_angle + 32'd32768;
    assign round_time  = prod_time + 32'd32768;

    assign op.mag  = mag_reg;
    assign op.alim = round_angle[31:16];
    assign op.tlim = round_time[31:16];
    assign op.now  = now_reg;
    assign op.mute = mute_reg;

    assign go = (state_reg == ST_DECIDE) && (!m_tvalid_reg || m_tready);

    satl_alarm u_alarm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go),
        .op      (op),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_ceiling_reg <= 16'd11520;
            time_ceiling_reg  <= 16'd2000;
            angle_decay_reg   <= 16'd655;
            time_decay_reg    <= 16'd655;
            mute_reg          <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                satl_pkg::REG_ANGLE_CEILING: angle_ceiling_reg <= cfg_data;
                satl_pkg::REG_TIME_CEILING:  time_ceiling_reg  <= cfg_data;
                satl_pkg::REG_ANGLE_DECAY:   angle_decay_reg   <= cfg_data;
                satl_pkg::REG_TIME_DECAY:    time_decay_reg    <= cfg_data;
                satl_pkg::REG_MUTE:          mute_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            // When a new decision lands in the same cycle, the output stays valid.
            if (m_tvalid_reg && m_tready && !go) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_MUL_X;
                    end
                end
                ST_MUL_X: begin
                    // Both lanes run in lock step.
                    if (done_angle && done_time) begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    state_reg <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    if (done_angle && done_time) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (go) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'b00000, res.buzzer_on, res.led_on, res.alarm_on};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            // Two's complement magnitude; the most negative code keeps its value.
            mag_reg <= pitch_in[16] ? (~pitch_in + 17'd1) : pitch_in;
            now_reg <= s_tdata[64:33];
        end
    end

endmodule

@@ rtl/satl_checker.sv @@
// Port-level checker for the tilt alarm, attached to the top level by bind.
// Depends only on the ports of speed_adaptive_tilt_alarm.
module satl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The LED only blinks while the alarm is on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
        else $error("led on without alarm");

    // The buzzer only sounds while the alarm is on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && !m_tdata[0]))
        else $error("buzzer on without alarm");

    // A sample is worked on alone: no new sample right after one is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while busy");

    // A result needs the multiplier passes, so it cannot appear the cycle after a
    // sample transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind speed_adaptive_tilt_alarm satl_checker u_satl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
